### hw/rtl/hoare_partition_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the partition engine RTL.
// ----------------------------------------------------------------------------
`ifndef HOARE_PARTITION_ENGINE_UNIT_MACROS_SVH
`define HOARE_PARTITION_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define HPE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define HPE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/hpe_pkg.sv
// ----------------------------------------------------------------------------
// hpe_pkg
// Widths, codes and state encoding of the partition engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hpe_pkg;

  localparam int DEPTH_DEFAULT  = 1024;
  localparam int ELEM_W_DEFAULT = 32;

  localparam int CMD_W   = 2;
  localparam int ADDR_W  = 10;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 11;  // holds right+1

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_PART  = 2'd2
  } cmd_t;

  localparam logic RES_READ = 1'b0;
  localparam logic RES_PART = 1'b1;

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_LOAD,
    ST_PIVOT,
    ST_OUTER,
    ST_I_WAIT,
    ST_J_RD,
    ST_J_WAIT,
    ST_SWAP_I,
    ST_SWAP_J,
    ST_FIN_RD,
    ST_FIN_WL,
    ST_FIN_WJ
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/hpe_channels.sv
// ----------------------------------------------------------------------------
// hpe channels
// Valid/ready channel interfaces: command, result and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpe_cmd_if
  import hpe_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [ADDR_W-1:0]   address;
  logic [DATA_W-1:0]   data;
  logic [ADDR_W-1:0]   range_left;
  logic [ADDR_W-1:0]   range_right;

  modport source (output valid, command, address, data, range_left, range_right,
                  input ready);
  modport sink   (input valid, command, address, data, range_left, range_right,
                  output ready);
endinterface

interface hpe_res_if
  import hpe_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [DATA_W-1:0]   read_data;
  logic [ADDR_W-1:0]   pivot_position;
  logic [ADDR_W-1:0]   lower_end;
  logic [IDX_W-1:0]    upper_start;
  logic                status;

  modport source (output valid, result_kind, read_data, pivot_position, lower_end,
                  upper_start, status, input ready);
  modport sink   (input valid, result_kind, read_data, pivot_position, lower_end,
                  upper_start, status, output ready);
endinterface

interface hpe_cfg_if;
  logic valid;
  logic ready;
  logic compare_signed;

  modport source (output valid, compare_signed, input ready);
  modport sink   (input valid, compare_signed, output ready);
endinterface

`default_nettype wire

### hw/rtl/hpe_ram.sv
// ----------------------------------------------------------------------------
// hpe_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/hoare_partition_engine_unit.sv
// ----------------------------------------------------------------------------
// hoare_partition_engine_unit
// Element memory with an in-place Hoare partition sequencer.
// ----------------------------------------------------------------------------
// The block keeps DEPTH elements in one simple dual-port RAM (one write, one
// registered read per cycle) and serves three commands on the cmd channel:
// write (stores data, no result), read (returns the element) and partition
// (rearranges range_left..range_right around the element at range_left and
// reports where the pivot landed). One command is worked on at a time; the
// result sits in an output register, and the next command is taken only once
// that register is empty or is being read out in the same cycle. A partition
// visits each element the two scans reach (about n for a range of n
// elements), with two RAM writes and the restart of the pass per exchange;
// every element visit is one access of the single RAM read port. A range
// that is reversed or runs past the memory returns status 1 and leaves the
// memory alone. Elements compare signed or unsigned according to
// compare_signed (reset: signed), which may be written only while the block
// is idle. Reading an element never written returns an undefined value.
// ----------------------------------------------------------------------------
`default_nettype none

module hoare_partition_engine_unit
  import hpe_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEFAULT,
  parameter int ELEMENT_WIDTH = ELEM_W_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  hpe_cmd_if.sink   cmd,
  hpe_res_if.source res,
  hpe_cfg_if.sink   cfg
);

`include "hoare_partition_engine_unit_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int EW = ELEMENT_WIDTH;

  // control state
  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   compare_signed;

  // scan registers
  logic [IDX_W-1:0] i_idx;
  logic [IDX_W-1:0] j_idx;
  logic [IDX_W-1:0] left_idx;
  logic [EW-1:0]    pivot;
  logic [EW-1:0]    elem_i;   // a[i] where the forward scan stopped
  logic [EW-1:0]    elem_j;   // a[j] where the backward scan stopped
  logic             rd_ok;

  // result register
  logic              out_kind;
  logic [DATA_W-1:0] out_data;
  logic [ADDR_W-1:0] out_pivot;
  logic [ADDR_W-1:0] out_lower;
  logic [IDX_W-1:0]  out_upper;
  logic              out_status;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic          cmd_fire;
  logic          out_free;
  logic          load_out;
  logic          addr_ok;
  logic          range_err;
  logic [EW-1:0] sign_mask;
  logic          i_less;    // a[i] < pivot
  logic          j_more;    // pivot < a[j]

  // flipping the sign bit makes the unsigned compare act as a signed one
  function automatic logic elem_less(input logic [EW-1:0] a, input logic [EW-1:0] b,
                                     input logic [EW-1:0] m);
    return (a ^ m) < (b ^ m);
  endfunction

  always_comb begin
    sign_mask         = '0;
    sign_mask[EW-1]   = compare_signed;
  end

  assign i_less = elem_less(ram_rdata, pivot, sign_mask);
  assign j_more = elem_less(pivot, ram_rdata, sign_mask);

  assign out_free  = !out_valid || res.ready;
  assign cmd.ready = (state == ST_IDLE) && out_free;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  assign addr_ok   = {22'd0, cmd.address} < 32'(DEPTH);
  assign range_err = (cmd.range_right < cmd.range_left)
                  || ({22'd0, cmd.range_right} >= 32'(DEPTH));

  hpe_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          case (cmd.command)
            CMD_READ: state_next = ST_RD_WAIT;
            CMD_PART: state_next = range_err ? ST_IDLE : ST_LOAD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD_WAIT: state_next = ST_IDLE;
      ST_LOAD:    state_next = ST_PIVOT;
      ST_PIVOT:   state_next = ST_OUTER;
      ST_OUTER: begin
        if (i_idx > j_idx) begin
          state_next = ST_FIN_RD;
        end else if (i_idx < j_idx) begin
          state_next = ST_I_WAIT;
        end else begin
          state_next = ST_J_RD;
        end
      end
      ST_I_WAIT: begin
        // keep scanning while a[i] is below the pivot and the next index is still below j
        if (!(i_less && ((i_idx + IDX_W'(1)) < j_idx))) begin
          state_next = ST_J_RD;
        end
      end
      ST_J_RD: state_next = ST_J_WAIT;
      ST_J_WAIT: begin
        if (!j_more) begin
          state_next = (i_idx >= j_idx) ? ST_FIN_RD : ST_SWAP_I;
        end
      end
      ST_SWAP_I: state_next = ST_SWAP_J;
      ST_SWAP_J: state_next = ST_OUTER;
      ST_FIN_RD: state_next = ST_FIN_WL;
      ST_FIN_WL: state_next = ST_FIN_WJ;
      ST_FIN_WJ: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // RAM control and result load
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ram_raddr = AW'(cmd.address);
        ram_waddr = AW'(cmd.address);
        ram_wdata = EW'(cmd.data);
        ram_we    = cmd_fire && (cmd.command == CMD_WRITE) && addr_ok;
        load_out  = cmd_fire && (cmd.command == CMD_PART) && range_err;
      end
      ST_RD_WAIT: load_out  = 1'b1;
      ST_LOAD:    ram_raddr = AW'(left_idx);
      ST_PIVOT:   ram_raddr = '0;
      ST_OUTER:   ram_raddr = AW'(i_idx);
      ST_I_WAIT:  ram_raddr = AW'(i_idx + IDX_W'(1));
      ST_J_RD:    ram_raddr = AW'(j_idx);
      ST_J_WAIT:  ram_raddr = AW'(j_idx - IDX_W'(1));
      ST_SWAP_I: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(i_idx);
        ram_wdata = elem_j;
      end
      ST_SWAP_J: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(j_idx);
        ram_wdata = elem_i;
      end
      ST_FIN_RD:  ram_raddr = AW'(j_idx);
      ST_FIN_WL: begin
        // a[left] still holds the pivot, so only a[j] needs reading
        ram_we    = 1'b1;
        ram_waddr = AW'(left_idx);
        ram_wdata = ram_rdata;
      end
      ST_FIN_WJ: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(j_idx);
        ram_wdata = pivot;
        load_out  = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      compare_signed <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        compare_signed <= cfg.compare_signed;
      end
      if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          rd_ok    <= addr_ok;
          left_idx <= IDX_W'(cmd.range_left);
          i_idx    <= IDX_W'(cmd.range_left) + IDX_W'(1);
          j_idx    <= IDX_W'(cmd.range_right);
        end
        if (load_out) begin
          out_kind   <= RES_PART;
          out_data   <= '0;
          out_pivot  <= '0;
          out_lower  <= '0;
          out_upper  <= '0;
          out_status <= STAT_ERR;
        end
      end
      ST_RD_WAIT: begin
        out_kind   <= RES_READ;
        out_data   <= rd_ok ? DATA_W'(ram_rdata) : '0;
        out_pivot  <= '0;
        out_lower  <= '0;
        out_upper  <= '0;
        out_status <= STAT_OK;
      end
      ST_PIVOT: pivot <= ram_rdata;
      ST_I_WAIT: begin
        if (i_less) begin
          i_idx <= i_idx + IDX_W'(1);
        end else begin
          elem_i <= ram_rdata;
        end
      end
      ST_J_WAIT: begin
        if (j_more) begin
          j_idx <= j_idx - IDX_W'(1);
        end else begin
          elem_j <= ram_rdata;
        end
      end
      ST_SWAP_J: begin
        i_idx <= i_idx + IDX_W'(1);
        j_idx <= j_idx - IDX_W'(1);
      end
      ST_FIN_WJ: begin
        out_kind   <= RES_PART;
        out_data   <= '0;
        out_pivot  <= ADDR_W'(j_idx);
        out_lower  <= (j_idx != '0) ? ADDR_W'(j_idx - IDX_W'(1)) : '0;
        out_upper  <= i_idx;
        out_status <= STAT_OK;
      end
      default: ;
    endcase
  end

  assign res.valid          = out_valid;
  assign res.result_kind    = out_kind;
  assign res.read_data      = out_data;
  assign res.pivot_position = out_pivot;
  assign res.lower_end      = out_lower;
  assign res.upper_start    = out_upper;
  assign res.status         = out_status;

  // backward scan never passes the pivot slot
  `HPE_ASSERT_IMP(a_j_floor, clk, rst, state == ST_J_WAIT, j_idx >= left_idx,
                  "backward scan went below range_left")
  // indexes cross by at most one between passes
  `HPE_ASSERT_IMP(a_cross, clk, rst, state == ST_OUTER,
                  {1'b0, i_idx} <= ({1'b0, j_idx} + (IDX_W+1)'(1)),
                  "scan indexes crossed by more than one")
  // no RAM write while a scan read is in flight
  `HPE_ASSERT_IMP(a_scan_no_write, clk, rst,
                  state == ST_I_WAIT || state == ST_J_WAIT, !ram_we,
                  "RAM written during a scan step")
  // a finished partition always posts its result
  `HPE_ASSERT_NXT(a_part_done, clk, rst, state == ST_FIN_WJ,
                  out_valid && out_kind == RES_PART && out_status == STAT_OK,
                  "partition finished without a result")

endmodule

`default_nettype wire

### verif/tb_hoare_partition_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_hoare_partition_engine_unit
// Self-checking bench for the partition engine: writes, reads and in-place
// Hoare partitions are predicted against a shadow copy of the element store
// and every result transfer is compared field by field, in order.
// ----------------------------------------------------------------------------

module tb_hoare_partition_engine_unit;
  import hpe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // command 3 is not decoded by the block: no result, no effect
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int MEM_DEPTH     = 1024;
  localparam int HOLD_CYCLES   = 400;        // long receiver hold-off
  localparam int SETTLE_CYCLES = 32;         // a write or ignored command in flight
  localparam int DRAIN_LIMIT   = 200000;     // final wait for outstanding results
  localparam int TIMEOUT_NS    = 40_000_000;

  typedef struct packed {
    logic               result_kind;
    logic [DATA_W-1:0]  read_data;
    logic [ADDR_W-1:0]  pivot_position;
    logic [ADDR_W-1:0]  lower_end;
    logic [IDX_W-1:0]   upper_start;
    logic               status;
  } engine_result_t;

  logic clk;
  logic rst;

  hpe_cmd_if cmd_ch ();
  hpe_res_if res_ch ();
  hpe_cfg_if cfg_ch ();

  hoare_partition_engine_unit u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // shadow of the element store and the ordering register
  logic [DATA_W-1:0] shadow_mem [MEM_DEPTH];
  bit                shadow_written [MEM_DEPTH];
  logic              signed_order;

  engine_result_t pending_results [$];

  int err_count;
  int items_sent;
  int results_checked;
  int partitions_done;
  int last_pivot;        // pivot position of the latest good partition
  int send_burst_left;   // sender transfers left with no idle gap
  int hold_req;          // bumped to ask the receiver for a long hold-off

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40)
      $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_idx();
    return ADDR_W'($urandom());
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    return $urandom();
  endfunction

  // element values; the narrow styles give duplicates and sign-bit crossings
  function automatic logic [DATA_W-1:0] elem_value(input int style);
    case (style)
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 5))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'hFFFF_FFFF;
          3: return 32'h8000_0000;
          4: return 32'h7FFF_FFFF;
          default: return 32'h0000_0002;
        endcase
      end
      2: return DATA_W'($signed($urandom_range(0, 16)) - 8);
      default: return (DATA_W'($urandom_range(0, 3)) << 30) | DATA_W'($urandom_range(0, 3));
    endcase
  endfunction

  // order key: flipping the sign bit makes unsigned compare act as signed
  function automatic bit elem_less(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ka, kb;
    ka = a ^ {signed_order, {(DATA_W-1){1'b0}}};
    kb = b ^ {signed_order, {(DATA_W-1){1'b0}}};
    return ka < kb;
  endfunction

  // --------------------------------------------------------------------------
  // prediction: applies one accepted command to the shadow store and queues
  // the result it should produce
  // --------------------------------------------------------------------------
  function automatic void predict_command(input logic [CMD_W-1:0] op,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [DATA_W-1:0] wdata,
                                          input logic [ADDR_W-1:0] lft,
                                          input logic [ADDR_W-1:0] rgt);
    engine_result_t r;
    logic [DATA_W-1:0] pivot, tmp;
    int i, j;
    r = '0;
    case (op)
      CMD_WRITE: begin
        shadow_mem[addr]     = wdata;
        shadow_written[addr] = 1'b1;
      end
      CMD_READ: begin
        r.result_kind = RES_READ;
        r.read_data   = shadow_mem[addr];
        r.status      = STAT_OK;
        pending_results.push_back(r);
      end
      CMD_PART: begin
        r.result_kind = RES_PART;
        if (rgt < lft) begin
          r.status = STAT_ERR;
        end else begin
          pivot = shadow_mem[lft];
          i = int'(lft) + 1;
          j = int'(rgt);
          while (i <= j) begin
            while (i < j && elem_less(shadow_mem[i], pivot)) i++;
            while (elem_less(pivot, shadow_mem[j])) j--;
            if (i >= j) break;
            tmp           = shadow_mem[i];
            shadow_mem[i] = shadow_mem[j];
            shadow_mem[j] = tmp;
            i++;
            j--;
          end
          tmp             = shadow_mem[j];
          shadow_mem[j]   = shadow_mem[lft];
          shadow_mem[lft] = tmp;
          r.pivot_position = ADDR_W'(j);
          r.lower_end      = (j > 0) ? ADDR_W'(j - 1) : '0;
          r.upper_start    = IDX_W'(i);
          r.status         = STAT_OK;
          last_pivot       = j;
          partitions_done++;
        end
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // command side
  // Called just after a rising edge; returns just after the edge that took
  // the transfer (or after the idle gap that follows it).
  // --------------------------------------------------------------------------
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] wdata, input logic [ADDR_W-1:0] lft,
                          input logic [ADDR_W-1:0] rgt);
    int g;
    cmd_ch.valid       <= 1'b1;
    cmd_ch.command     <= op;
    cmd_ch.address     <= addr;
    cmd_ch.data        <= wdata;
    cmd_ch.range_left  <= lft;
    cmd_ch.range_right <= rgt;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_command(op, addr, wdata, lft, rgt);
    if (op != CMD_UNUSED) items_sent++;
    if (send_burst_left > 0) begin
      send_burst_left--;
      g = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) send_burst_left = $urandom_range(20, 80);
      g = pick_gap();
    end
    if (g > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // sender goes quiet until every predicted result has come back; writes and
  // ignored commands give no result, so allow them a few cycles to retire
  task automatic wait_results_done();
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_compare_mode(input logic mode);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.compare_signed <= mode;
    do @(posedge clk); while (!cfg_ch.ready);
    signed_order = mode;
    cfg_ch.valid <= 1'b0;
  endtask

  // a random address that already holds data
  function automatic int pick_written_addr();
    int a, k;
    for (k = 0; k < 32; k++) begin
      a = $urandom_range(0, MEM_DEPTH - 1);
      if (shadow_written[a]) return a;
    end
    a = $urandom_range(0, MEM_DEPTH - 1);
    for (k = 0; k < MEM_DEPTH; k++)
      if (shadow_written[(a + k) % MEM_DEPTH]) return (a + k) % MEM_DEPTH;
    return 0;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus building blocks
  // --------------------------------------------------------------------------

  // fill a fresh range, partition it, recurse into one side a few times the
  // way quicksort would, then read some of it back
  task automatic run_sequence();
    int n, base, style, k, lft, rgt, r;
    r = $urandom_range(0, 99);
    if (r < 70)      n = $urandom_range(1, 8);
    else if (r < 95) n = $urandom_range(9, 24);
    else             n = $urandom_range(25, 48);
    base  = $urandom_range(0, MEM_DEPTH - n);
    style = $urandom_range(0, 3);
    for (k = 0; k < n; k++)
      send_cmd(CMD_WRITE, ADDR_W'(base + k), elem_value(style), rand_idx(), rand_idx());
    lft = base;
    rgt = base + n - 1;
    for (k = 0; k < 3; k++) begin
      send_cmd(CMD_PART, rand_idx(), rand_word(), ADDR_W'(lft), ADDR_W'(rgt));
      if ($urandom_range(0, 1) && last_pivot > lft)
        rgt = last_pivot - 1;
      else if (last_pivot < rgt)
        lft = last_pivot + 1;
      else
        break;
    end
    repeat ($urandom_range(0, 3))
      send_cmd(CMD_READ, ADDR_W'(base + $urandom_range(0, n - 1)), rand_word(),
               rand_idx(), rand_idx());
  endtask

  // odd single commands between sequences
  task automatic run_noise();
    int a, b;
    case ($urandom_range(0, 4))
      0: send_cmd(CMD_READ, ADDR_W'(pick_written_addr()), rand_word(), rand_idx(), rand_idx());
      1: begin
        // reversed range
        a = $urandom_range(1, MEM_DEPTH - 1);
        b = $urandom_range(0, a - 1);
        send_cmd(CMD_PART, rand_idx(), rand_word(), ADDR_W'(a), ADDR_W'(b));
      end
      2: send_cmd(CMD_UNUSED, rand_idx(), rand_word(), rand_idx(), rand_idx());
      3: send_cmd(CMD_WRITE, rand_idx(), rand_word(), rand_idx(), rand_idx());
      default: begin
        // re-partition a stretch that is already populated
        a = pick_written_addr();
        b = a;
        while (b < MEM_DEPTH - 1 && shadow_written[b + 1] && b - a < 30) b++;
        send_cmd(CMD_PART, rand_idx(), rand_word(), ADDR_W'(a), ADDR_W'(b));
      end
    endcase
  endtask

  task automatic run_random(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 99) < 75) run_sequence();
      else run_noise();
      if ($urandom_range(0, 29) == 0) wait_results_done();
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // field extremes, every command, reversed and single-element ranges,
  // all-equal range, unused command; runs at the reset ordering (signed)
  task automatic test_directed_corners();
    int k;
    send_cmd(CMD_WRITE, 10'd0, 32'h8000_0000, 10'h3FF, 10'h3FF);
    send_cmd(CMD_WRITE, 10'd1, 32'h7FFF_FFFF, 10'h000, 10'h000);
    send_cmd(CMD_WRITE, 10'd2, 32'h0000_0000, rand_idx(), rand_idx());
    send_cmd(CMD_WRITE, 10'd3, 32'hFFFF_FFFF, rand_idx(), rand_idx());
    send_cmd(CMD_WRITE, 10'h3FF, 32'hA5A5_A5A5, rand_idx(), rand_idx());
    send_cmd(CMD_WRITE, 10'h3FE, 32'h0000_0000, rand_idx(), rand_idx());
    send_cmd(CMD_READ, 10'd0, 32'hFFFF_FFFF, rand_idx(), rand_idx());
    send_cmd(CMD_READ, 10'h3FF, 32'h0000_0000, rand_idx(), rand_idx());
    // pivot is the most negative value: j runs all the way back to left
    send_cmd(CMD_PART, 10'h3FF, 32'h0, 10'd0, 10'd3);
    // range ending at the top address
    send_cmd(CMD_PART, 10'h000, 32'h0, 10'h3FE, 10'h3FF);
    send_cmd(CMD_PART, 10'h000, 32'h0, 10'h3FF, 10'h3FF);
    // reversed ranges
    send_cmd(CMD_PART, 10'h000, 32'h0, 10'h3FF, 10'h000);
    send_cmd(CMD_PART, 10'h000, 32'h0, 10'd1, 10'd0);
    send_cmd(CMD_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF);
    send_cmd(CMD_READ, 10'd2, 32'h0, rand_idx(), rand_idx());
    // all elements equal: both scans stop at once, so every pass swaps until they meet
    for (k = 4; k < 8; k++)
      send_cmd(CMD_WRITE, ADDR_W'(k), 32'h0000_0042, rand_idx(), rand_idx());
    send_cmd(CMD_PART, 10'h000, 32'h0, 10'd4, 10'd7);
    send_cmd(CMD_READ, 10'd4, 32'h0, rand_idx(), rand_idx());
    send_cmd(CMD_READ, 10'd7, 32'h0, rand_idx(), rand_idx());
    send_cmd(CMD_READ, 10'h3FE, 32'h0, rand_idx(), rand_idx());
  endtask

  task automatic test_random_signed();
    wait_results_done();
    write_compare_mode(1'b1);
    run_random(450);
  endtask

  // same stored values reorder once the sign bit counts as magnitude
  task automatic test_unsigned_order();
    wait_results_done();
    write_compare_mode(1'b0);
    send_cmd(CMD_PART, rand_idx(), rand_word(), 10'd0, 10'd3);
    send_cmd(CMD_READ, 10'd0, rand_word(), rand_idx(), rand_idx());
    send_cmd(CMD_READ, 10'd3, rand_word(), rand_idx(), rand_idx());
    run_random(350);
  endtask

  // receiver holds off for a long stretch while commands keep coming, so the
  // result register fills and the command channel stalls
  task automatic test_output_backpressure();
    int k, base;
    wait_results_done();
    write_compare_mode(1'b1);
    base = $urandom_range(0, MEM_DEPTH - 16);
    for (k = 0; k < 16; k++)
      send_cmd(CMD_WRITE, ADDR_W'(base + k), elem_value(0), rand_idx(), rand_idx());
    hold_req <= hold_req + 1;
    send_burst_left = 48;
    for (k = 0; k < 48; k++) begin
      if (k % 3 == 0)
        send_cmd(CMD_PART, rand_idx(), rand_word(), ADDR_W'(base + $urandom_range(0, 7)),
                 ADDR_W'(base + 15));
      else
        send_cmd(CMD_READ, ADDR_W'(base + $urandom_range(0, 15)), rand_word(),
                 rand_idx(), rand_idx());
    end
    wait_results_done();
  endtask

  // each sequence starts from an empty pipeline
  task automatic test_sender_pause();
    int k;
    wait_results_done();
    write_compare_mode(1'b0);
    for (k = 0; k < 12; k++) begin
      run_sequence();
      wait_results_done();
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: ready with random stalls, plus the long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int wait_left;
    int burst_left;
    int hold_seen;
    wait_left  = 0;
    burst_left = 0;
    hold_seen  = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        wait_left = HOLD_CYCLES;
      end
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (wait_left > 0) begin
        res_ch.ready <= 1'b0;
        wait_left--;
      end else begin
        res_ch.ready <= 1'b1;
        if (burst_left > 0) burst_left--;
        else if ($urandom_range(0, 99) < 3) burst_left = $urandom_range(20, 80);
        else wait_left = pick_gap();
      end
    end
  end

  // compare every result transfer against the oldest prediction
  initial begin
    engine_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with no command waiting for one");
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", DATA_W'(res_ch.result_kind), DATA_W'(want.result_kind));
          check_field("read_data", res_ch.read_data, want.read_data);
          check_field("pivot_position", DATA_W'(res_ch.pivot_position),
                      DATA_W'(want.pivot_position));
          check_field("lower_end", DATA_W'(res_ch.lower_end), DATA_W'(want.lower_end));
          check_field("upper_start", DATA_W'(res_ch.upper_start), DATA_W'(want.upper_start));
          check_field("status", DATA_W'(res_ch.status), DATA_W'(want.status));
          results_checked++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #TIMEOUT_NS;
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int n;
    rst                   = 1'b1;
    cmd_ch.valid          = 1'b0;
    cmd_ch.command        = CMD_WRITE;
    cmd_ch.address        = '0;
    cmd_ch.data           = '0;
    cmd_ch.range_left     = '0;
    cmd_ch.range_right    = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.compare_signed = 1'b1;
    signed_order          = 1'b1;   // reset ordering
    err_count             = 0;
    items_sent            = 0;
    results_checked       = 0;
    partitions_done       = 0;
    last_pivot            = 0;
    send_burst_left       = 0;
    hold_req              = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_random_signed();
    test_unsigned_order();
    test_output_backpressure();
    test_sender_pause();

    // drain, bounded
    cmd_ch.valid <= 1'b0;
    n = 0;
    while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived",
                                pending_results.size()));

    $display("Ran %0d commands in signed and unsigned order, %0d results checked,",
             items_sent, results_checked);
    $display("%0d good partitions, with output hold-off and drained pauses.",
             partitions_done);
    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
